@@ hw/rtl/kpc_pkg.sv @@
// ----------------------------------------------------------------------------
// kpc_pkg
// Shared types, codes and helpers for the key press short/long classifier.
// ----------------------------------------------------------------------------
package kpc_pkg;

  localparam int unsigned KeyW   = 3;
  localparam int unsigned PinW   = 4;
  localparam int unsigned TimerW = 8;
  localparam int unsigned CfgW   = 8;
  localparam int unsigned PhaseW = 2;

  localparam logic [PhaseW-1:0] PhaseIdle     = 2'd0;
  localparam logic [PhaseW-1:0] PhaseDebounce = 2'd1;
  localparam logic [PhaseW-1:0] PhaseConfirm  = 2'd2;
  localparam logic [PhaseW-1:0] PhaseHold     = 2'd3;

  localparam logic [KeyW-1:0] KeyNone = 3'd0;
  localparam logic [KeyW-1:0] KeyInc  = 3'd1;
  localparam logic [KeyW-1:0] KeyDec  = 3'd2;
  localparam logic [KeyW-1:0] KeyOk   = 3'd3;
  localparam logic [KeyW-1:0] KeyMenu = 3'd4;

  localparam logic PressShort = 1'b0;
  localparam logic PressLong  = 1'b1;

  localparam logic CfgDebounce  = 1'b0;
  localparam logic CfgLongPress = 1'b1;

  localparam logic [TimerW-1:0] TimerMax = '1;

  typedef struct packed {
    logic            valid;
    logic            kind;
    logic [KeyW-1:0] key;
  } kpc_res_t;

  // Active-low pins, menu highest priority.
  function automatic logic [KeyW-1:0] encode_key(input logic [PinW-1:0] pins);
    logic [KeyW-1:0] k;
    k = KeyNone;
    priority if (!pins[3]) k = KeyMenu;
    else if (!pins[2])     k = KeyOk;
    else if (!pins[1])     k = KeyDec;
    else if (!pins[0])     k = KeyInc;
    else                   k = KeyNone;
    return k;
  endfunction

endpackage

@@ hw/rtl/key_press_short_long_classifier_top.sv @@
// ----------------------------------------------------------------------------
// key_press_short_long_classifier_top
// Classifies short and long presses of four active-low buttons from scans.
//
//   channel  dir  payload
//   s_axis   in   tdata[3:0] pin_levels, tdata[4] tick
//   m_axis   out  tdata[2:0] key_id, tuser press_kind
//   cfg      in   idx 0 debounce_ticks, idx 1 long_press_ticks
//
// One scan per cycle while the output is not stalled. A scan is held in the
// input register, is evaluated by the state machine and its result, if any,
// lands in the output register. The input side keeps accepting while the
// output register holds a result, as long as the result is taken in the same
// cycle. Reset clears the state and loads the default timings.
// ----------------------------------------------------------------------------
module key_press_short_long_classifier_top import kpc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [7:0]      s_axis_tdata_i,   // [3:0] pin_levels, [4] tick
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [2:0] key_id
  output logic            m_axis_tuser_o,   // [0] press_kind
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_wdata_i
);

  logic [CfgW-1:0] deb_q, lp_q;
  logic            in_vld_q;
  logic [PinW-1:0] pins_q;
  logic            tick_q;
  logic            out_vld_q;
  logic            kind_q;
  logic [KeyW-1:0] key_q;
  logic            step;
  kpc_res_t        res;

  assign step            = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || step;

  kpc_fsm u_fsm (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (step),
    .pins_i             (pins_q),
    .tick_i             (tick_q),
    .debounce_ticks_i   (deb_q),
    .long_press_ticks_i (lp_q),
    .res_o              (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q <= CfgW'(1);
      lp_q  <= CfgW'(10);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDebounce:  deb_q <= cfg_wdata_i;
        CfgLongPress: lp_q  <= cfg_wdata_i;
        default:      deb_q <= deb_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) in_vld_q <= s_axis_tvalid_i;
      if (step) out_vld_q <= res.valid;
      else if (m_axis_tready_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      pins_q <= s_axis_tdata_i[PinW-1:0];
      tick_q <= s_axis_tdata_i[PinW];
    end
    if (step && res.valid) begin
      kind_q <= res.kind;
      key_q  <= res.key;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'b0, key_q};
  assign m_axis_tuser_o  = kind_q;

endmodule

@@ hw/rtl/kpc_fsm.sv @@
// ----------------------------------------------------------------------------
// kpc_fsm
// Debounce and hold-timing state machine; one scan evaluated per step.
// ----------------------------------------------------------------------------
module kpc_fsm import kpc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [PinW-1:0]   pins_i,
  input  logic              tick_i,
  input  logic [CfgW-1:0]   debounce_ticks_i,
  input  logic [CfgW-1:0]   long_press_ticks_i,
  output kpc_res_t          res_o
);

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [KeyW-1:0]   held_key_q, held_key_d;
  logic [KeyW-1:0]   pend_key_q, pend_key_d;
  logic [TimerW-1:0] timer_q, timer_d;
  logic [TimerW-1:0] timer_inc;
  logic [KeyW-1:0]   key;

  always_comb begin
    key       = encode_key(pins_i);
    timer_inc = (tick_i && timer_q != TimerMax) ? timer_q + TimerW'(1) : timer_q;
    phase_d    = phase_q;
    held_key_d = held_key_q;
    pend_key_d = pend_key_q;
    timer_d    = timer_inc;
    res_o      = '{valid: 1'b0, kind: PressShort, key: KeyNone};
    unique case (phase_q)
      PhaseIdle: begin
        if (key != KeyNone) begin
          held_key_d = key;
          timer_d    = '0;
          phase_d    = PhaseDebounce;
        end
      end
      PhaseDebounce: begin
        if (timer_inc >= debounce_ticks_i) phase_d = PhaseConfirm;
      end
      PhaseConfirm: begin
        if (key == held_key_q) begin
          timer_d    = '0;
          pend_key_d = key;
          phase_d    = PhaseHold;
        end else begin
          phase_d = PhaseIdle;
        end
      end
      PhaseHold: begin
        if (key == held_key_q) begin
          if (timer_inc >= long_press_ticks_i) begin
            res_o   = '{valid: 1'b1, kind: PressLong, key: key};
            phase_d = PhaseIdle;
          end
        end else begin
          res_o      = '{valid: 1'b1, kind: PressShort, key: pend_key_q};
          pend_key_d = KeyNone;
          phase_d    = PhaseIdle;
        end
      end
      default: phase_d = PhaseIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhaseIdle;
      held_key_q <= KeyNone;
      pend_key_q <= KeyNone;
      timer_q    <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      held_key_q <= held_key_d;
      pend_key_q <= pend_key_d;
      timer_q    <= timer_d;
    end
  end

endmodule
